// ===== src/pts_pkg.sv =====
// ============================================================================
// pts_pkg: shared types and constants of the padded tensor element store
// Field widths, register and status codes, and the lane and layout records.
// ============================================================================
`default_nettype none

package pts_pkg;

	localparam int NUM_DIMS   = 4;
	localparam int DIM_W      = $clog2(NUM_DIMS);
	localparam int NDIMS_W    = 3;
	localparam int SIZE_W     = 13;
	localparam int IDX_W      = 16;
	localparam int STRIDE_W   = 16;
	localparam int WORD_W     = 32;
	localparam int ADDR_OUT_W = 12;
	localparam int STATUS_W   = 2;
	localparam int TERM_W     = SIZE_W + STRIDE_W;
	localparam int SUM_W      = TERM_W + DIM_W;

	// Padding unit of the strides; it must stay a power of two because the
	// stride low bits are padded modulo 2**STRIDE_W.
	localparam int PAD_UNIT   = 16;

	// Index magnitude bits resolved per cycle in each lane.
	localparam int DIGIT_BITS = 4;
	localparam int DIV_STEPS  = IDX_W / DIGIT_BITS;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam int REG_IDX_W  = 3;
	localparam int APB_ADDR_W = REG_IDX_W + 2;
	localparam int APB_DATA_W = 32;

	typedef logic [SIZE_W-1:0]   dim_size_t;
	typedef logic [STRIDE_W-1:0] stride_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_NO_ARRAY = 2'd1;
	localparam status_t STATUS_OVERSIZE = 2'd2;

	localparam reg_idx_t REG_NUM_DIMS = 3'd0;
	localparam reg_idx_t REG_SIZE_D0  = 3'd1;
	localparam reg_idx_t REG_SIZE_D1  = 3'd2;
	localparam reg_idx_t REG_SIZE_D2  = 3'd3;
	localparam reg_idx_t REG_SIZE_D3  = 3'd4;

	typedef struct packed {
		logic                       busy;
		status_t                    status;
		stride_t [NUM_DIMS-1:0]     strides;
	} layout_info_t;

	typedef struct packed {
		logic start;
		logic used;
	} lane_ctl_t;

	function automatic logic [NDIMS_W-1:0] dims_used(input logic [NDIMS_W-1:0] nd);
		return (nd > NDIMS_W'(NUM_DIMS)) ? NDIMS_W'(NUM_DIMS) : nd;
	endfunction

endpackage

`default_nettype wire

// ===== src/pts_req_if.sv =====
// ============================================================================
// pts_req_if: access request channel
// Carries one element access: operation, four signed indices and a word.
// ============================================================================
`default_nettype none

interface pts_req_if;
	import pts_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic signed [IDX_W-1:0] index_0;
	logic signed [IDX_W-1:0] index_1;
	logic signed [IDX_W-1:0] index_2;
	logic signed [IDX_W-1:0] index_3;
	logic [WORD_W-1:0]       write_word;

	modport source (
		output valid, operation, index_0, index_1, index_2, index_3, write_word,
		input  ready
	);

	modport sink (
		input  valid, operation, index_0, index_1, index_2, index_3, write_word,
		output ready
	);

endinterface

`default_nettype wire

// ===== src/pts_rsp_if.sv =====
// ============================================================================
// pts_rsp_if: access result channel
// Carries the element word, its flat address and the access status.
// ============================================================================
`default_nettype none

interface pts_rsp_if;
	import pts_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [WORD_W-1:0]     read_word;
	logic [ADDR_OUT_W-1:0] word_address;
	logic [STATUS_W-1:0]   status;

	modport source (
		output valid, read_word, word_address, status,
		input  ready
	);

	modport sink (
		input  valid, read_word, word_address, status,
		output ready
	);

endinterface

`default_nettype wire

// ===== src/pts_ram.sv =====
// ============================================================================
// pts_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module pts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= store_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/pts_lane.sv =====
// ============================================================================
// pts_lane: one dimension of the address computation
// Wraps a signed index by floor modulo of the dimension size with a radix-16
// remainder unit, then scales the wrapped index by the dimension stride.
// ============================================================================
`default_nettype none

module pts_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pts_pkg::lane_ctl_t            ctl,
	input  logic signed [pts_pkg::IDX_W-1:0] index,
	input  pts_pkg::dim_size_t            size,
	input  pts_pkg::stride_t              stride,
	output logic                          done,
	output logic [pts_pkg::TERM_W-1:0]    term
);
	import pts_pkg::*;

	localparam int REM_W = SIZE_W + 1;

	logic                div_q;
	logic                mul_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;

	logic [IDX_W-1:0]    mag_q;
	logic                neg_q;
	logic                used_q;
	logic [SIZE_W-1:0]   rem_q;
	dim_size_t           size_q;
	stride_t             stride_q;
	logic [TERM_W-1:0]   term_q;

	logic [IDX_W-1:0]    raw;
	logic [IDX_W-1:0]    mag_in;
	logic [REM_W-1:0]    part;
	logic [SIZE_W-1:0]   rem_nxt;
	logic [SIZE_W-1:0]   wrapped;
	logic [TERM_W-1:0]   prod;

	assign raw    = index;
	assign mag_in = raw[IDX_W-1] ? (~raw + IDX_W'(1)) : raw;

	// Restoring remainder, DIGIT_BITS bits of the magnitude per cycle.
	always_comb begin
		rem_nxt = rem_q;
		part    = '0;
		for (int k = 0; k < DIGIT_BITS; k++) begin
			part = {rem_nxt, mag_q[IDX_W-1-k]};
			if (part >= {1'b0, size_q}) begin
				part = part - {1'b0, size_q};
			end
			rem_nxt = part[SIZE_W-1:0];
		end
	end

	// A negative index with a nonzero remainder wraps to size minus remainder.
	assign wrapped = (neg_q && (rem_q != '0)) ? (size_q - rem_q) : rem_q;
	assign prod    = {{STRIDE_W{1'b0}}, wrapped} * {{SIZE_W{1'b0}}, stride_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= 1'b0;
			mul_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (ctl.start) begin
			div_q  <= 1'b1;
			mul_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (div_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				div_q <= 1'b0;
				mul_q <= 1'b1;
			end
		end else if (mul_q) begin
			mul_q  <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mag_q    <= mag_in;
			neg_q    <= raw[IDX_W-1];
			used_q   <= ctl.used;
			rem_q    <= '0;
			size_q   <= size;
			stride_q <= stride;
		end else if (div_q) begin
			mag_q <= mag_q << DIGIT_BITS;
			rem_q <= rem_nxt;
		end
		if (mul_q) begin
			term_q <= used_q ? prod : '0;
		end
	end

	assign done = done_q;
	assign term = term_q;

endmodule

`default_nettype wire

// ===== src/pts_layout.sv =====
// ============================================================================
// pts_layout: stride and layout status sequencer
// Walks the dimensions from innermost to outermost, one multiply per cycle,
// padding strides and tracking a saturated total for the size check.
// ============================================================================
`default_nettype none

module pts_layout #(
	parameter int STORE_WORDS = 4096
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [pts_pkg::NDIMS_W-1:0]                 num_dims,
	input  pts_pkg::dim_size_t [pts_pkg::NUM_DIMS-1:0]  sizes,
	output pts_pkg::layout_info_t                       info
);
	import pts_pkg::*;

	// The saturated total is capped at a multiple of the pad unit that lies
	// above any store depth, so the oversize decision stays exact.
	localparam int SAT_W  = $clog2(STORE_WORDS) + 2;
	localparam int CAP    = 2 ** (SAT_W - 1);
	localparam int PROD_W = SIZE_W + SAT_W;
	localparam int LO_W   = SIZE_W + STRIDE_W;
	localparam logic [SAT_W-1:0]    SAT_PAD = SAT_W'(PAD_UNIT - 1);
	localparam logic [STRIDE_W-1:0] LO_PAD  = STRIDE_W'(PAD_UNIT - 1);

	logic                busy_q;
	logic                fin_q;
	logic [DIM_W-1:0]    idx_q;
	status_t             status_q;
	stride_t             run_lo_q;
	logic [SAT_W-1:0]    run_sat_q;
	stride_t [NUM_DIMS-1:0] stride_q;

	logic [NDIMS_W-1:0]  n_used;
	logic [NDIMS_W-1:0]  d_ext;
	dim_size_t           mul_size;
	logic [LO_W-1:0]     prod_lo;
	logic [PROD_W-1:0]   prod_sat;
	stride_t             raw_lo;
	stride_t             pad_lo;
	logic [SAT_W-1:0]    raw_sat;
	logic [SAT_W-1:0]    pad_sat;
	stride_t             st_lo;
	logic [SAT_W-1:0]    st_sat;
	logic                zero_any;
	status_t             status_nxt;

	assign n_used   = dims_used(num_dims);
	assign d_ext    = NDIMS_W'(idx_q);
	assign mul_size = fin_q ? sizes[0] : sizes[idx_q + DIM_W'(1)];

	assign prod_lo  = {{STRIDE_W{1'b0}}, mul_size} * {{SIZE_W{1'b0}}, run_lo_q};
	assign prod_sat = {{SAT_W{1'b0}}, mul_size} * {{SIZE_W{1'b0}}, run_sat_q};

	assign raw_lo   = prod_lo[STRIDE_W-1:0];
	assign pad_lo   = (raw_lo + LO_PAD) & ~LO_PAD;
	assign raw_sat  = (prod_sat >= PROD_W'(CAP)) ? SAT_W'(CAP) : prod_sat[SAT_W-1:0];
	assign pad_sat  = (raw_sat + SAT_PAD) & ~SAT_PAD;

	always_comb begin
		if (d_ext >= n_used) begin
			st_lo  = '0;
			st_sat = '0;
		end else if (d_ext == n_used - NDIMS_W'(1)) begin
			st_lo  = STRIDE_W'(1);
			st_sat = SAT_W'(1);
		end else if (mul_size != SIZE_W'(1)) begin
			st_lo  = pad_lo;
			st_sat = pad_sat;
		end else begin
			st_lo  = raw_lo;
			st_sat = raw_sat;
		end
	end

	always_comb begin
		zero_any = 1'b0;
		for (int d = 0; d < NUM_DIMS; d++) begin
			if ((NDIMS_W'(d) < n_used) && (sizes[d] == '0)) begin
				zero_any = 1'b1;
			end
		end
	end

	// In the final step the multiplier forms the outermost size times stride.
	always_comb begin
		if ((n_used == '0) || zero_any) begin
			status_nxt = STATUS_NO_ARRAY;
		end else if (pad_sat > SAT_W'(STORE_WORDS)) begin
			status_nxt = STATUS_OVERSIZE;
		end else begin
			status_nxt = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			fin_q    <= 1'b0;
			idx_q    <= DIM_W'(NUM_DIMS - 1);
			status_q <= STATUS_NO_ARRAY;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			idx_q  <= DIM_W'(NUM_DIMS - 1);
		end else if (busy_q) begin
			if (fin_q) begin
				status_q <= status_nxt;
				busy_q   <= 1'b0;
				fin_q    <= 1'b0;
			end else if (idx_q == '0) begin
				fin_q <= 1'b1;
			end else begin
				idx_q <= idx_q - DIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !fin_q && !start) begin
			stride_q[idx_q] <= (sizes[idx_q] == SIZE_W'(1)) ? '0 : st_lo;
			run_lo_q        <= st_lo;
			run_sat_q       <= st_sat;
		end
	end

	assign info.busy    = busy_q;
	assign info.status  = status_q;
	assign info.strides = stride_q;

endmodule

`default_nettype wire

// ===== src/padded_tensor_element_store.sv =====
// Each accepted item passes in order through the lanes (each lane forms
// the radix-16 floor remainder, then scales it), the lane merge, a read or
// write of the element memory and the output register; no new item is
// accepted before its result is loaded. Reset and every write to a mapped
// register start a clearing pass over all STORE_WORDS words (4096 by
// default) of the element memory; no item is accepted until it ends.
// ============================================================================
// padded_tensor_element_store: strided tensor word store with padding
// Holds a tensor of up to four dimensions, wraps signed indices per dimension
// and reads or writes the addressed word through an APB-configured layout.
// ============================================================================
`default_nettype none

module padded_tensor_element_store #(
	parameter int STORE_WORDS = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pts_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [pts_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pts_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	pts_req_if.sink                          req,
	pts_rsp_if.source                        rsp
);
	import pts_pkg::*;

	localparam int AW = $clog2(STORE_WORDS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LANES = 2'd1;
	localparam logic [1:0] ST_MEM   = 2'd2;
	localparam logic [1:0] ST_DATA  = 2'd3;

	// Configuration registers
	logic [NDIMS_W-1:0]       num_dims_q;
	dim_size_t [NUM_DIMS-1:0] size_q;
	reg_idx_t                 reg_idx;
	logic                     cfg_wr;
	logic                     cfg_hit;
	logic [NDIMS_W-1:0]       n_used;

	// Clearing pass
	logic                     clear_q;
	logic [AW-1:0]            clr_addr_q;

	// Access sequencing
	logic [1:0]               state_q;
	logic                     accept;
	logic                     busy;
	logic                     op_q;
	logic [WORD_W-1:0]        wdata_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         sum_c;
	status_t                  acc_status;
	status_t                  res_status_q;
	logic                     mem_we;
	logic                     mem_re;
	logic                     load;

	// Output register
	logic                     rsp_valid_q;
	logic [WORD_W-1:0]        read_word_q;
	logic [ADDR_OUT_W-1:0]    word_address_q;
	status_t                  status_q;

	// Lanes and layout
	layout_info_t             info;
	lane_ctl_t                lane_ctl  [NUM_DIMS];
	logic signed [IDX_W-1:0]  lane_idx  [NUM_DIMS];
	logic [NUM_DIMS-1:0]      lane_done;
	logic [TERM_W-1:0]        lane_term [NUM_DIMS];
	logic                     all_done;

	// Memory ports
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [WORD_W-1:0]        ram_wdata;
	logic [WORD_W-1:0]        ram_rdata;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_hit = cfg_wr && (reg_idx <= REG_SIZE_D3);
	assign n_used  = dims_used(num_dims_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= '0;
			for (int d = 0; d < NUM_DIMS; d++) begin
				size_q[d] <= SIZE_W'(1);
			end
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NUM_DIMS: num_dims_q <= pwdata[NDIMS_W-1:0];
				REG_SIZE_D0:  size_q[0]  <= pwdata[SIZE_W-1:0];
				REG_SIZE_D1:  size_q[1]  <= pwdata[SIZE_W-1:0];
				REG_SIZE_D2:  size_q[2]  <= pwdata[SIZE_W-1:0];
				REG_SIZE_D3:  size_q[3]  <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NUM_DIMS: prdata = APB_DATA_W'(num_dims_q);
			REG_SIZE_D0:  prdata = APB_DATA_W'(size_q[0]);
			REG_SIZE_D1:  prdata = APB_DATA_W'(size_q[1]);
			REG_SIZE_D2:  prdata = APB_DATA_W'(size_q[2]);
			REG_SIZE_D3:  prdata = APB_DATA_W'(size_q[3]);
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Layout sequencer
	// ------------------------------------------------------------------
	pts_layout #(
		.STORE_WORDS (STORE_WORDS)
	) u_layout (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_hit),
		.num_dims (num_dims_q),
		.sizes    (size_q),
		.info     (info)
	);

	// ------------------------------------------------------------------
	// Clearing pass: any shape change empties the whole store.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (cfg_hit) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			if (clr_addr_q == AW'(STORE_WORDS - 1)) begin
				clear_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Lanes
	// ------------------------------------------------------------------
	assign busy      = clear_q || info.busy;
	assign req.ready = (state_q == ST_IDLE) && !busy;
	assign accept    = req.valid && req.ready;

	assign lane_idx[0] = req.index_0;
	assign lane_idx[1] = req.index_1;
	assign lane_idx[2] = req.index_2;
	assign lane_idx[3] = req.index_3;

	always_comb begin
		for (int d = 0; d < NUM_DIMS; d++) begin
			lane_ctl[d].start = accept;
			lane_ctl[d].used  = (NDIMS_W'(d) < n_used);
		end
	end

	for (genvar g = 0; g < NUM_DIMS; g++) begin : g_lane
		pts_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl[g]),
			.index  (lane_idx[g]),
			.size   (size_q[g]),
			.stride (info.strides[g]),
			.done   (lane_done[g]),
			.term   (lane_term[g])
		);
	end

	assign all_done = &lane_done;

	// Merge: the flat address is the sum of the lane terms.
	always_comb begin
		sum_c = '0;
		for (int d = 0; d < NUM_DIMS; d++) begin
			sum_c = sum_c + SUM_W'(lane_term[d]);
		end
	end

	always_comb begin
		if (info.status != STATUS_OK) begin
			acc_status = info.status;
		end else if (sum_q >= SUM_W'(STORE_WORDS)) begin
			acc_status = STATUS_OVERSIZE;
		end else begin
			acc_status = STATUS_OK;
		end
	end

	assign mem_we = (state_q == ST_MEM) && (acc_status == STATUS_OK) && op_q;
	assign mem_re = (state_q == ST_MEM) && (acc_status == STATUS_OK) && !op_q;
	assign load   = (state_q == ST_DATA) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LANES;
					end
				end
				ST_LANES: begin
					if (all_done) begin
						state_q <= ST_MEM;
					end
				end
				ST_MEM: begin
					state_q <= ST_DATA;
				end
				ST_DATA: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			wdata_q <= req.write_word;
		end
		if ((state_q == ST_LANES) && all_done) begin
			sum_q <= sum_c;
		end
		if (state_q == ST_MEM) begin
			res_status_q <= acc_status;
		end
	end

	// ------------------------------------------------------------------
	// Element memory
	// ------------------------------------------------------------------
	assign ram_we    = clear_q || mem_we;
	assign ram_waddr = clear_q ? clr_addr_q : sum_q[AW-1:0];
	assign ram_wdata = clear_q ? '0 : wdata_q;

	pts_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (mem_re),
		.raddr (sum_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// After a successful write the result word is the word just stored.
	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= res_status_q;
			if (res_status_q != STATUS_OK) begin
				read_word_q    <= '0;
				word_address_q <= '0;
			end else begin
				read_word_q    <= op_q ? wdata_q : ram_rdata;
				word_address_q <= sum_q[ADDR_OUT_W-1:0];
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.read_word    = read_word_q;
	assign rsp.word_address = word_address_q;
	assign rsp.status       = status_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> (!clear_q && !info.busy))
		else $error("word accepted during clearing pass or layout update");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (!clear_q && (sum_q < SUM_W'(STORE_WORDS))))
		else $error("element write outside the store");

	a_accept_starts_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_LANES))
		else $error("accepted word did not start the lanes");

	a_error_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != STATUS_OK)) |->
			((rsp.read_word == '0) && (rsp.word_address == '0)))
		else $error("error result carries nonzero word or address");

endmodule

`default_nettype wire

// ===== tb/tb_padded_tensor_element_store.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_padded_tensor_element_store: self-checking bench for the tensor store
// Programs shapes over APB, drives element reads and writes with random
// gaps and stalls, and checks every result against an in-bench layout and
// memory predictor.
// ============================================================================

module tb_padded_tensor_element_store;
	import pts_pkg::*;

	localparam int       CLK_PERIOD    = 12;
	localparam int       TENSOR_WORDS  = 4096;
	localparam int       CYCLE_LIMIT   = 1000000;
	localparam int       MAX_IDLE      = 17;
	localparam int       REPORT_LIMIT  = 10;
	localparam int       SETTLE_CYCLES = 16;
	localparam int       RANDOM_PHASES = 8;
	localparam int       PHASE_ITEMS   = 170;
	localparam int       HOLD_CYCLES   = 400;
	localparam logic     OP_READ       = 1'b0;
	localparam logic     OP_WRITE      = 1'b1;
	localparam reg_idx_t REG_SPARE     = 3'd5;

	typedef struct packed {
		logic                           operation;
		logic [NUM_DIMS-1:0][IDX_W-1:0] index;
		logic [WORD_W-1:0]              write_word;
	} access_t;

	typedef struct packed {
		logic [WORD_W-1:0]     read_word;
		logic [ADDR_OUT_W-1:0] word_address;
		status_t               status;
	} access_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	pts_req_if req_ch ();
	pts_rsp_if rsp_ch ();

	padded_tensor_element_store uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// Shadow copy of the shape registers, the derived layout and the memory.
	logic [NDIMS_W-1:0]            shape_dims;
	dim_size_t [NUM_DIMS-1:0]      shape_sizes;
	stride_t [NUM_DIMS-1:0]        shape_strides;
	status_t                       shape_status;
	logic [WORD_W-1:0]             tensor_words [0:TENSOR_WORDS-1];

	access_result_t                predicted_accesses [$];
	logic [NUM_DIMS-1:0][IDX_W-1:0] written_spots [$];

	int unsigned failure_count;
	int unsigned results_seen;
	int unsigned cycle_count;
	int          rsp_hold_cycles;
	bit          sender_pauses;
	bit          receiver_pauses;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	function automatic int unsigned active_dims(input logic [NDIMS_W-1:0] nd);
		return (nd > NUM_DIMS) ? NUM_DIMS : int'(nd);
	endfunction

	function automatic longint unsigned round_to_pad(input longint unsigned x);
		longint unsigned r;
		r = x % PAD_UNIT;
		return (r != 0) ? x + (PAD_UNIT - r) : x;
	endfunction

	// Row-major strides, each padded unless the next size is one; the total
	// decides whether the layout fits the memory at all.
	function automatic void compute_layout(input logic [NDIMS_W-1:0] nd,
			input dim_size_t [NUM_DIMS-1:0] sz, output stride_t [NUM_DIMS-1:0] st_out,
			output status_t stat);
		longint unsigned st [NUM_DIMS];
		longint unsigned total;
		int unsigned     n;
		bit              any_zero;
		n = active_dims(nd);
		any_zero = 1'b0;
		for (int i = 0; i < NUM_DIMS; i++) st[i] = 0;
		if (n == 0) begin
			total = round_to_pad(1);
		end else begin
			st[n-1] = 1;
			for (int i = int'(n) - 2; i >= 0; i--) begin
				st[i] = longint'(sz[i+1]) * st[i+1];
				if (sz[i+1] != 1) st[i] = round_to_pad(st[i]);
			end
			total = round_to_pad(st[0] * longint'(sz[0]));
			for (int i = 0; i < int'(n); i++) begin
				if (sz[i] == 1) st[i] = 0;
				if (sz[i] == 0) any_zero = 1'b1;
			end
		end
		for (int i = 0; i < NUM_DIMS; i++) st_out[i] = st[i][STRIDE_W-1:0];
		if (n == 0 || any_zero || total == 0) stat = STATUS_NO_ARRAY;
		else if (total > TENSOR_WORDS) stat = STATUS_OVERSIZE;
		else stat = STATUS_OK;
	endfunction

	function automatic access_result_t predict_element_access(input access_t a);
		access_result_t  res;
		longint unsigned flat;
		longint          idx;
		longint          s;
		res = '0;
		if (shape_status != STATUS_OK) begin
			res.status = shape_status;
			return res;
		end
		flat = 0;
		for (int d = 0; d < int'(active_dims(shape_dims)); d++) begin
			idx = longint'($signed(a.index[d]));
			s = longint'(shape_sizes[d]);
			flat += longint'(((idx % s) + s) % s) * longint'(shape_strides[d]);
		end
		if (flat >= TENSOR_WORDS) begin
			res.status = STATUS_OVERSIZE;
			return res;
		end
		if (a.operation == OP_WRITE) tensor_words[flat] = a.write_word;
		res.read_word = tensor_words[flat];
		res.word_address = flat[ADDR_OUT_W-1:0];
		res.status = STATUS_OK;
		return res;
	endfunction

	function automatic access_t make_access(input logic op, input int i0, input int i1,
			input int i2, input int i3, input logic [WORD_W-1:0] word);
		access_t a;
		a.operation = op;
		a.index[0] = IDX_W'(i0);
		a.index[1] = IDX_W'(i1);
		a.index[2] = IDX_W'(i2);
		a.index[3] = IDX_W'(i3);
		a.write_word = word;
		return a;
	endfunction

	function automatic logic [IDX_W-1:0] pick_index(input int size);
		int v;
		if (size == 0) return IDX_W'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = $urandom_range(0, size - 1);
			5:             v = -int'($urandom_range(1, size));
			6, 7:          v = $urandom_range(0, 65535);
			8: begin
				case ($urandom_range(0, 3))
					0:       v = -32768;
					1:       v = 32767;
					2:       v = 0;
					default: v = -1;
				endcase
			end
			default: v = (int'($urandom_range(0, 8)) - 4) * size + int'($urandom_range(0, 3));
		endcase
		return IDX_W'(v);
	endfunction

	// Mostly fresh coordinates, sometimes a spot written earlier so that
	// reads see stored words rather than cleared memory.
	function automatic access_t random_access();
		access_t a;
		a.operation = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_READ;
		a.write_word = $urandom;
		if (written_spots.size() != 0 && $urandom_range(0, 9) < 3) begin
			a.index = written_spots[$urandom_range(0, written_spots.size() - 1)];
		end else begin
			for (int d = 0; d < NUM_DIMS; d++)
				a.index[d] = (d < int'(active_dims(shape_dims))) ?
					pick_index(int'(shape_sizes[d])) : IDX_W'($urandom);
		end
		if (a.operation == OP_WRITE) begin
			written_spots.push_back(a.index);
			if (written_spots.size() > 16) void'(written_spots.pop_front());
		end
		return a;
	endfunction

	task automatic log_failure(input string what);
		failure_count++;
		if (failure_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
	endtask

	// Returns right after the edge at which the word was taken.
	task automatic send_access(input access_t a);
		int gap;
		gap = sender_pauses ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= a.operation;
		req_ch.index_0    <= a.index[0];
		req_ch.index_1    <= a.index[1];
		req_ch.index_2    <= a.index[2];
		req_ch.index_3    <= a.index[3];
		req_ch.write_word <= a.write_word;
		do @(posedge clk); while (!req_ch.ready);
		predicted_accesses.push_back(predict_element_access(a));
	endtask

	task automatic wait_for_idle();
		req_ch.valid <= 1'b0;
		while (predicted_accesses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Every write to a mapped register rebuilds the layout and clears the memory;
	// writes to unmapped addresses leave both untouched.
	task automatic write_register(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (idx <= REG_SIZE_D3) begin
			if (idx == REG_NUM_DIMS) shape_dims = value[NDIMS_W-1:0];
			else shape_sizes[idx - REG_SIZE_D0] = value[SIZE_W-1:0];
			compute_layout(shape_dims, shape_sizes, shape_strides, shape_status);
			for (int i = 0; i < TENSOR_WORDS; i++) tensor_words[i] = '0;
		end
	endtask

	task automatic configure_shape(input logic [NDIMS_W-1:0] nd, input int s0, input int s1,
			input int s2, input int s3);
		wait_for_idle();
		write_register(REG_NUM_DIMS, APB_DATA_W'(nd));
		write_register(REG_SIZE_D0, APB_DATA_W'(s0));
		write_register(REG_SIZE_D1, APB_DATA_W'(s1));
		write_register(REG_SIZE_D2, APB_DATA_W'(s2));
		write_register(REG_SIZE_D3, APB_DATA_W'(s3));
		written_spots.delete();
	endtask

	task automatic test_no_array();
		send_access(make_access(OP_WRITE, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send_access(make_access(OP_READ, -32768, 32767, -1, 0, 32'h0));
		configure_shape(0, 4096, 4096, 4096, 4096);
		send_access(make_access(OP_WRITE, 32767, -32768, 0, -1, 32'h8000_0001));
		send_access(make_access(OP_READ, 1, 1, 1, 1, 32'h0));
	endtask

	task automatic test_single_dim_extremes();
		configure_shape(1, 4096, 1, 1, 1);
		send_access(make_access(OP_WRITE, -32768, 32767, -32768, 32767, 32'hFFFF_FFFF));
		send_access(make_access(OP_READ, 32767, -1, 0, -32768, 32'h0));
		send_access(make_access(OP_WRITE, -1, 0, 0, 0, 32'hA5A5_5A5A));
		send_access(make_access(OP_READ, 32767, 0, 0, 0, 32'h0));
		send_access(make_access(OP_READ, 0, -1, -1, -1, 32'hFFFF_FFFF));
	endtask

	task automatic test_four_dim_padding();
		configure_shape(4, 3, 5, 7, 2);
		send_access(make_access(OP_WRITE, 2, 4, 6, 1, 32'h1234_5678));
		send_access(make_access(OP_READ, -1, -1, -1, -1, 32'h0));
		send_access(make_access(OP_WRITE, 0, 0, 0, 0, 32'h0000_0001));
		send_access(make_access(OP_READ, 3, 5, 7, 2, 32'h0));
	endtask

	// More dimensions than supported are clipped, and unit sizes collapse
	// their strides; the unmapped register must change nothing.
	task automatic test_unit_sizes();
		configure_shape(7, 1, 16, 1, 4);
		write_register(REG_SPARE, 32'hFFFF_FFFF);
		send_access(make_access(OP_WRITE, 5, -1, 9, -3, 32'hDEAD_BEEF));
		send_access(make_access(OP_READ, 0, 15, 0, 1, 32'h0));
		send_access(make_access(OP_READ, 7, 31, -2, 5, 32'h0));
	endtask

	task automatic test_zero_size();
		configure_shape(3, 4, 0, 4, 1);
		send_access(make_access(OP_WRITE, 1, 1, 1, 0, 32'h5555_AAAA));
		send_access(make_access(OP_READ, 1, 1, 1, 0, 32'h0));
	endtask

	task automatic test_oversize();
		configure_shape(2, 4096, 2, 1, 1);
		send_access(make_access(OP_WRITE, 1, 1, 0, 0, 32'h7777_7777));
		send_access(make_access(OP_READ, 1, 1, 0, 0, 32'h0));
		// The padded total of this shape saturates its counter.
		configure_shape(4, 4096, 4096, 4096, 4096);
		send_access(make_access(OP_READ, 0, 0, 0, 0, 32'h0));
	endtask

	// The receiver stops for a long stretch while words keep coming, so the
	// pipeline fills and the request side has to stall.
	task automatic test_backpressure();
		configure_shape(3, 6, 5, 9, 1);
		sender_pauses = 1'b0;
		receiver_pauses = 1'b0;
		rsp_hold_cycles = HOLD_CYCLES;
		repeat (60) send_access(random_access());
	endtask

	task automatic test_random_layouts();
		logic [NDIMS_W-1:0]       nd;
		dim_size_t [NUM_DIMS-1:0] sz;
		stride_t [NUM_DIMS-1:0]   st;
		status_t                  stat;
		bit                       want_ok;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			want_ok = ($urandom_range(0, 7) != 0);
			for (int attempt = 0; attempt < 64; attempt++) begin
				nd = ($urandom_range(0, 7) == 0) ? NDIMS_W'($urandom_range(5, 7)) :
					NDIMS_W'($urandom_range(1, 4));
				for (int d = 0; d < NUM_DIMS; d++)
					sz[d] = ($urandom_range(0, 3) == 0) ? SIZE_W'(1) :
						SIZE_W'($urandom_range(2, (nd == 1) ? 4096 : 12));
				if (!want_ok && $urandom_range(0, 1) == 1)
					sz[$urandom_range(0, NUM_DIMS - 1)] = '0;
				compute_layout(nd, sz, st, stat);
				if ((stat == STATUS_OK) == want_ok) break;
			end
			configure_shape(nd, sz[0], sz[1], sz[2], sz[3]);
			sender_pauses = (phase % 3 != 0);
			receiver_pauses = (phase % 4 != 1);
			repeat (PHASE_ITEMS) send_access(random_access());
		end
	endtask

	initial begin : rsp_pacer
		int gap;
		gap = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				gap = receiver_pauses ? $urandom_range(0, MAX_IDLE) : 0;
			if (rsp_hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold_cycles--;
			end else if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				gap--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : access_result_check
		access_result_t want;
		access_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.read_word, rsp_ch.word_address, rsp_ch.status};
				results_seen++;
				if (predicted_accesses.size() == 0) begin
					log_failure($sformatf(
						"result %0d arrived with none pending: word %h addr %0d status %0d",
						results_seen, got.read_word, got.word_address, got.status));
				end else begin
					want = predicted_accesses.pop_front();
					if (got.read_word !== want.read_word ||
							got.word_address !== want.word_address ||
							got.status !== want.status)
						log_failure($sformatf({"result %0d: expected word %h addr %0d status %0d, ",
							"got word %h addr %0d status %0d"}, results_seen, want.read_word,
							want.word_address, want.status, got.read_word, got.word_address,
							got.status));
				end
			end
		end
	end

	initial begin
		failure_count = 0;
		results_seen = 0;
		rsp_hold_cycles = 0;
		sender_pauses = 1'b1;
		receiver_pauses = 1'b1;
		shape_dims = '0;
		for (int d = 0; d < NUM_DIMS; d++) shape_sizes[d] = SIZE_W'(1);
		compute_layout(shape_dims, shape_sizes, shape_strides, shape_status);
		for (int i = 0; i < TENSOR_WORDS; i++) tensor_words[i] = '0;

		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.operation  <= OP_READ;
		req_ch.index_0    <= '0;
		req_ch.index_1    <= '0;
		req_ch.index_2    <= '0;
		req_ch.index_3    <= '0;
		req_ch.write_word <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_array();
		test_single_dim_extremes();
		test_four_dim_padding();
		test_unit_sizes();
		test_zero_size();
		test_oversize();
		test_backpressure();
		test_random_layouts();
		wait_for_idle();

		if (failure_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== padded_tensor_element_store.f =====
src/pts_pkg.sv
src/pts_req_if.sv
src/pts_rsp_if.sv
src/pts_ram.sv
src/pts_lane.sv
src/pts_layout.sv
src/padded_tensor_element_store.sv
tb/tb_padded_tensor_element_store.sv
